// ===== design/moia_pkg.sv =====
// Shared package for the multi-op integer ALU: opcodes, status codes, widths
// and the request type passed from the front end through the queue.
// No dependencies.
package moia_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int FW        = 49;
  // Divider dividend width: magnitude of a (33 bits) shifted by FRAC_BITS.
  localparam int DIVW      = 33 + FRAC_BITS;
  // Root argument width: a shifted by 2*FRAC_BITS, an even width.
  localparam int SQW       = 32 + 2 * FRAC_BITS;
  localparam int SQR       = SQW / 2;
  localparam int QDEPTH    = 4;
  localparam int QAW       = 2;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_REM  = 3'd5,
    OP_SQRT = 3'd6,
    OP_AVG  = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADOP = 2'd1,
    ST_DIV0  = 2'd2,
    ST_NEGRT = 2'd3
  } status_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    opcode_t        op;
    status_t        st;
    logic [DW-1:0]  a;
    logic [DW-1:0]  b;
  } req_t;

endpackage

// ===== design/moia_front.sv =====
// Front end: takes requests, classifies them and checks error conditions.
// Depends on moia_pkg.
module moia_front (
  input  logic                 in_start,
  input  logic [2:0]           in_opcode,
  input  logic signed [31:0]   in_operand_a,
  input  logic signed [31:0]   in_operand_b,
  input  logic                 q_full,
  output logic                 busy,
  output logic                 push,
  output moia_pkg::req_t       push_req
);

  logic [2:0] cls_op;

  // The front end stalls only when the queue has no room.
  assign busy = q_full;
  assign push = in_start && !q_full;
  assign cls_op = in_opcode;

  // Classify the request and flag errors up front.
  always_comb begin
    push_req.op = moia_pkg::opcode_t'(cls_op);
    push_req.a  = in_operand_a;
    push_req.b  = in_operand_b;
    push_req.st = moia_pkg::ST_OK;
    unique case (moia_pkg::opcode_t'(cls_op))
      moia_pkg::OP_NONE: push_req.st = moia_pkg::ST_BADOP;
      moia_pkg::OP_DIV, moia_pkg::OP_REM: begin
        if (in_operand_b == '0) push_req.st = moia_pkg::ST_DIV0;
      end
      moia_pkg::OP_SQRT: begin
        if (in_operand_a[31]) push_req.st = moia_pkg::ST_NEGRT;
      end
      default: push_req.st = moia_pkg::ST_OK;
    endcase
  end

endmodule

// ===== design/moia_queue.sv =====
// Short request queue between front and back end (flip-flop FIFO).
// Depends on moia_pkg.
module moia_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  moia_pkg::req_t  push_req,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output moia_pkg::req_t  head
);

  moia_pkg::req_t                 mem_r [moia_pkg::QDEPTH];
  logic [moia_pkg::QAW-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [moia_pkg::QAW:0]         cnt_r, cnt_nxt;

  assign full  = (cnt_r == (moia_pkg::QAW+1)'(moia_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  // Pointer and count update.
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (moia_pkg::QAW+1)'(push) - (moia_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_req;
  end

endmodule

// ===== design/moia_back.sv =====
// Back end: pipelined arithmetic. One radix-2 divider stage and one
// restoring root stage per cycle, with the simple ops carried alongside.
// Depends on moia_pkg.
module moia_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  moia_pkg::req_t       head,
  output logic                 pop,
  output logic                 out_strobe,
  output logic signed [31:0]   out_int_result,
  output logic signed [48:0]   out_fixed_result,
  output logic [1:0]           out_status
);

  localparam int NS = moia_pkg::DIVW;   // stage count, root needs fewer
  localparam int DW = moia_pkg::DIVW;
  localparam int SW = moia_pkg::SQW;
  localparam int RW = moia_pkg::SQR;

  // Per-stage pipeline payload.
  typedef struct packed {
    logic                 v;
    moia_pkg::opcode_t    op;
    moia_pkg::status_t    st;
    logic                 neg;
    logic [31:0]          ir;
    logic [DW-1:0]        n;     // dividend bits, shifted out MSB first
    logic [32:0]          d;     // divisor magnitude
    logic [33:0]          rem;   // partial remainder
    logic [DW-1:0]        q;     // quotient bits
    logic [SW-1:0]        x;     // root argument, two bits a step
    logic [RW+1:0]        sr;    // root remainder
    logic [RW-1:0]        root;
  } stg_t;

  stg_t s_r [NS+1];
  stg_t s_nxt [NS+1];
  stg_t st0;

  logic [32:0] ma, mb, ms;
  logic [32:0] sum33;
  logic [31:0] prod;

  assign pop = !q_empty;

  // Stage 0: operand setup and the add, subtract and multiply results.
  always_comb begin
    ma    = head.a[31] ? 33'(-$signed({1'b1, head.a})) : {1'b0, head.a};
    mb    = head.b[31] ? 33'(-$signed({1'b1, head.b})) : {1'b0, head.b};
    sum33 = 33'($signed(head.a)) + 33'($signed(head.b));
    ms    = sum33[32] ? 33'(-$signed(sum33)) : sum33;
    prod  = head.a * head.b;
    st0      = '0;
    st0.v    = pop;
    st0.op   = head.op;
    st0.st   = head.st;
    st0.d    = mb;
    st0.n    = DW'({ma, moia_pkg::FRAC_BITS'(0)});
    st0.x    = SW'({head.a, (2*moia_pkg::FRAC_BITS)'(0)});
    unique case (head.op)
      moia_pkg::OP_ADD: st0.ir = head.a + head.b;
      moia_pkg::OP_SUB: st0.ir = head.a - head.b;
      moia_pkg::OP_MUL: st0.ir = prod;
      moia_pkg::OP_DIV: st0.neg = head.a[31] ^ head.b[31];
      moia_pkg::OP_REM: begin
        // The remainder divides the plain magnitude, with no fraction bits.
        st0.neg = head.a[31];
        st0.n   = DW'(ma);
      end
      moia_pkg::OP_AVG: begin
        st0.neg = sum33[32];
        st0.q   = DW'({ms, moia_pkg::FRAC_BITS'(0)} >> 1);
      end
      default: st0.ir = '0;
    endcase
  end

  // Each stage: one divide step and, in the first RW stages, one root step.
  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [33:0]   tr;
    logic [RW+1:0] tsr;
    logic [RW+1:0] trial;
    always_comb begin
      s_nxt[i+1] = s_r[i];
      if (s_r[i].op == moia_pkg::OP_DIV || s_r[i].op == moia_pkg::OP_REM) begin
        tr = {s_r[i].rem[32:0], s_r[i].n[DW-1]};
        s_nxt[i+1].n = {s_r[i].n[DW-2:0], 1'b0};
        if (tr >= {1'b0, s_r[i].d}) begin
          s_nxt[i+1].rem = tr - {1'b0, s_r[i].d};
          s_nxt[i+1].q   = {s_r[i].q[DW-2:0], 1'b1};
        end else begin
          s_nxt[i+1].rem = tr;
          s_nxt[i+1].q   = {s_r[i].q[DW-2:0], 1'b0};
        end
      end else begin
        tr = '0;
      end
      tsr   = '0;
      trial = '0;
      if (i < RW && s_r[i].op == moia_pkg::OP_SQRT) begin
        tsr   = {s_r[i].sr[RW-1:0], s_r[i].x[SW-1 -: 2]};
        trial = {s_r[i].root, 2'b01};
        s_nxt[i+1].x = {s_r[i].x[SW-3:0], 2'b00};
        if (tsr >= trial) begin
          s_nxt[i+1].sr   = tsr - trial;
          s_nxt[i+1].root = {s_r[i].root[RW-2:0], 1'b1};
        end else begin
          s_nxt[i+1].sr   = tsr;
          s_nxt[i+1].root = {s_r[i].root[RW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb s_nxt[0] = st0;

  // Pipeline registers.
  for (genvar i = 0; i <= NS; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) s_r[i] <= '0;
      else        s_r[i] <= s_nxt[i];
    end
  end

  // Final formatting and output register.
  logic                 ostb_r;
  logic [31:0]          oi_r, oi_nxt;
  logic [48:0]          of_r, of_nxt;
  logic [1:0]           os_r;
  stg_t                 fin;
  assign fin = s_r[NS];

  always_comb begin
    oi_nxt = fin.ir;
    of_nxt = '0;
    unique case (fin.op)
      moia_pkg::OP_DIV: of_nxt = fin.neg ? 49'(-fin.q) : 49'(fin.q);
      moia_pkg::OP_REM: oi_nxt = fin.neg ? 32'(-fin.rem) : fin.rem[31:0];
      moia_pkg::OP_SQRT: of_nxt = 49'(fin.root);
      moia_pkg::OP_AVG: of_nxt = fin.neg ? 49'(-fin.q) : 49'(fin.q);
      default: of_nxt = '0;
    endcase
    if (fin.st != moia_pkg::ST_OK) begin
      oi_nxt = '0;
      of_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ostb_r <= 1'b0;
    else        ostb_r <= fin.v;
  end

  always_ff @(posedge clk) begin
    oi_r <= oi_nxt;
    of_r <= of_nxt;
    os_r <= fin.st;
  end

  assign out_strobe       = ostb_r;
  assign out_int_result   = oi_r;
  assign out_fixed_result = of_r;
  assign out_status       = os_r;

endmodule

// ===== design/multi_op_integer_alu_core.sv =====
// Top level of the multi-op integer ALU: front end, request queue, back end.
// Depends on moia_pkg, moia_front, moia_queue and moia_back.
//
//  channel  | handshake          | payload
//  in_      | start / busy       | in_opcode, in_operand_a, in_operand_b
//  out_     | out_strobe         | out_int_result, out_fixed_result, out_status
//
// One request per cycle is accepted; each request goes through the queue, the
// setup stage, the 49-stage radix-2 divider pipeline that every request passes
// through, and the output register. Reset is synchronous; after it the queue is
// empty and no result is pending. The back end pops the queue every cycle, so
// busy stays low.
// The receiver cannot stall; each result shows for one cycle.
module multi_op_integer_alu_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_opcode,
  input  logic signed [31:0]   in_operand_a,
  input  logic signed [31:0]   in_operand_b,
  output logic                 out_strobe,
  output logic signed [31:0]   out_int_result,
  output logic signed [48:0]   out_fixed_result,
  output logic [1:0]           out_status
);

  logic            q_full, q_empty, push, pop;
  moia_pkg::req_t  push_req, head;

  moia_front u_front (
    .in_start(start), .in_opcode, .in_operand_a, .in_operand_b,
    .q_full, .busy, .push, .push_req
  );

  moia_queue u_queue (
    .clk, .rst_n, .push, .push_req, .pop, .full(q_full), .empty(q_empty), .head
  );

  moia_back u_back (
    .clk, .rst_n, .q_empty, .head, .pop, .out_strobe, .out_int_result,
    .out_fixed_result, .out_status
  );

endmodule

// ===== design/moia_checker.sv =====
// Port-level checker for the multi-op integer ALU, bound to the top level.
// Depends on moia_pkg.
module moia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [31:0] out_int_result,
  input logic [48:0] out_fixed_result,
  input logic [1:0]  out_status
);

  // An error result carries zero payload.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != moia_pkg::ST_OK |->
      out_int_result == '0 && out_fixed_result == '0)
    else $error("error result with nonzero payload");

  // No result right after reset.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");

  // Integer and fixed results never both nonzero.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_int_result == '0 || out_fixed_result == '0)
    else $error("both result fields set");

  // The queue drains every cycle, so a request is never held off.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("request stalled by busy");

endmodule

bind multi_op_integer_alu_core moia_checker u_moia_checker (
  .clk, .rst_n, .start, .busy, .out_strobe, .out_int_result,
  .out_fixed_result, .out_status
);

// ===== sim/tb_top.sv =====
// Testbench for multi_op_integer_alu_core: directed and random requests with a
// built-in arithmetic predictor and an in-order checker of strobed results.
// Depends on moia_pkg and the design files.
module tb_top;

  localparam int LATENCY    = 60;
  localparam int WATCHDOG   = 2000;
  localparam int RAND_ITEMS = 800;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    int          gap;
    bit          drain;
  } alu_req_t;

  typedef struct {
    logic [31:0] ir;
    logic [48:0] fr;
    logic [1:0]  st;
  } alu_res_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_opcode;
  logic signed [31:0] in_operand_a;
  logic signed [31:0] in_operand_b;
  logic               out_strobe;
  logic signed [31:0] out_int_result;
  logic signed [48:0] out_fixed_result;
  logic [1:0]         out_status;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       errors = 0;
  int       idle_cycles;
  bit       stim_done = 1'b0;
  int       wait_cnt;

  multi_op_integer_alu_core dut (.*);

  // Clock generation.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Integer square root of a 64-bit value, bit by bit.
  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Compute the expected result of one request.
  function automatic alu_res_t alu_predict(input logic [2:0] op, input logic [31:0] a32,
                                           input logic [31:0] b32);
    alu_res_t    r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] s;
    logic [63:0] q;
    a  = {{32{a32[31]}}, a32};
    b  = {{32{b32[31]}}, b32};
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    r.ir = '0;
    r.fr = '0;
    r.st = moia_pkg::ST_OK;
    case (op)
      moia_pkg::OP_ADD: r.ir = a32 + b32;
      moia_pkg::OP_SUB: r.ir = a32 - b32;
      moia_pkg::OP_MUL: r.ir = a32 * b32;
      moia_pkg::OP_DIV: begin
        if (b32 == 0) begin
          r.st = moia_pkg::ST_DIV0;
        end else begin
          q = (ma << moia_pkg::FRAC_BITS) / mb;
          if (a[63] != b[63]) q = -q;
          r.fr = q[48:0];
        end
      end
      moia_pkg::OP_REM: begin
        if (b32 == 0) begin
          r.st = moia_pkg::ST_DIV0;
        end else begin
          q = ma % mb;
          if (a[63]) q = -q;
          r.ir = q[31:0];
        end
      end
      moia_pkg::OP_SQRT: begin
        if (a[63]) begin
          r.st = moia_pkg::ST_NEGRT;
        end else begin
          q = isqrt(a << (2 * moia_pkg::FRAC_BITS));
          r.fr = q[48:0];
        end
      end
      moia_pkg::OP_AVG: begin
        s = a + b;
        q = ((s[63] ? -s : s) << moia_pkg::FRAC_BITS) / 2;
        if (s[63]) q = -q;
        r.fr = q[48:0];
      end
      default: r.st = moia_pkg::ST_BADOP;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3) - 1;
      3: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b,
                         input bit drain);
    alu_req_t q;
    q.op    = op;
    q.a     = a;
    q.b     = b;
    q.gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    q.drain = drain;
    pending_reqs.push_back(q);
  endtask

  // Build directed and random requests, then release reset.
  initial begin
    rst_n     = 1'b0;
    add_req(moia_pkg::OP_NONE, 32'h1234, 32'h5678, 0);
    add_req(moia_pkg::OP_ADD, 32'h7fff_ffff, 32'd1, 0);
    add_req(moia_pkg::OP_ADD, 32'h8000_0000, 32'hffff_ffff, 0);
    add_req(moia_pkg::OP_SUB, 32'h8000_0000, 32'd1, 0);
    add_req(moia_pkg::OP_SUB, 32'h0, 32'h8000_0000, 0);
    add_req(moia_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 0);
    add_req(moia_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
    add_req(moia_pkg::OP_DIV, 32'd7, 32'd0, 0);
    add_req(moia_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0);
    add_req(moia_pkg::OP_DIV, 32'hffff_fff9, 32'd2, 0);
    add_req(moia_pkg::OP_DIV, 32'h7fff_ffff, 32'd1, 0);
    add_req(moia_pkg::OP_REM, 32'd7, 32'd0, 0);
    add_req(moia_pkg::OP_REM, 32'h8000_0000, 32'hffff_ffff, 0);
    add_req(moia_pkg::OP_REM, 32'hffff_fff9, 32'd3, 0);
    add_req(moia_pkg::OP_SQRT, 32'hffff_ffff, 32'd0, 0);
    add_req(moia_pkg::OP_SQRT, 32'h7fff_ffff, 32'h1, 0);
    add_req(moia_pkg::OP_SQRT, 32'd0, 32'd0, 0);
    add_req(moia_pkg::OP_SQRT, 32'd2, 32'd9, 0);
    add_req(moia_pkg::OP_AVG, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    add_req(moia_pkg::OP_AVG, 32'h8000_0000, 32'h8000_0000, 0);
    add_req(moia_pkg::OP_AVG, 32'hffff_ffff, 32'd0, 0);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      add_req($urandom_range(0, 7), rand_operand(), rand_operand(),
              (i == RAND_ITEMS / 2));
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: one request per queue entry, with random gaps and one drain pause.
  always @(posedge clk) begin
    if (!rst_n) begin
      start        <= 1'b0;
      in_opcode    <= '0;
      in_operand_a <= '0;
      in_operand_b <= '0;
      wait_cnt     <= 0;
    end else if (start && busy) begin
      // Hold the current request until it is taken.
    end else begin
      if (start) begin
        expected_results.push_back(alu_predict(in_opcode, in_operand_a, in_operand_b));
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() == 0) begin
        start     <= 1'b0;
        stim_done <= 1'b1;
      end else if (pending_reqs[0].drain && (expected_results.size() != 0 || start)) begin
        start <= 1'b0;
      end else if (wait_cnt < pending_reqs[0].gap) begin
        start    <= 1'b0;
        wait_cnt <= wait_cnt + 1;
      end else begin
        start        <= 1'b1;
        in_opcode    <= pending_reqs[0].op;
        in_operand_a <= pending_reqs[0].a;
        in_operand_b <= pending_reqs[0].b;
        wait_cnt     <= 0;
        pending_reqs[0].drain = 0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    alu_res_t e;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ir=%h fr=%h st=%0d", $time,
                 out_int_result, out_fixed_result, out_status);
      end else begin
        e = expected_results.pop_front();
        if (out_int_result !== e.ir) begin
          errors++;
          $display("%0t: int_result expected %h actual %h", $time, e.ir, out_int_result);
        end
        if (out_fixed_result !== e.fr) begin
          errors++;
          $display("%0t: fixed_result expected %h actual %h", $time, e.fr,
                   out_fixed_result);
        end
        if (out_status !== e.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_status);
        end
      end
    end
  end

  // Watchdog on cycles in which no request or result is accepted.
  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // End of run: wait for all results, let the pipeline settle, then report.
  initial begin
    wait (stim_done === 1'b1);
    wait (expected_results.size() == 0);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
